### hw/rtl/sm83_alu_with_flags_top_assert.svh
// ============================================================================
// SM83 ALU assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ============================================================================
`ifndef SM83_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define SM83_ALU_WITH_FLAGS_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SM83_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sm83 alu assertion failed");
`define SM83_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sm83 alu assertion failed");
`else
`define SM83_ASSERT(label, prop)
`define SM83_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/sm83alu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// SM83 ALU package
// Operation codes, flag positions, constants and item types of the SM83 ALU.
// ============================================================================
package sm83alu_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLCA  = 5'd10,
        OP_RLA   = 5'd11,
        OP_RRCA  = 5'd12,
        OP_RRA   = 5'd13,
        OP_RLC   = 5'd14,
        OP_RRC   = 5'd15,
        OP_RL    = 5'd16,
        OP_RR    = 5'd17,
        OP_SLA   = 5'd18,
        OP_SRA   = 5'd19,
        OP_SWAP  = 5'd20,
        OP_SRL   = 5'd21,
        OP_BIT   = 5'd22,
        OP_RES   = 5'd23,
        OP_SET   = 5'd24,
        OP_DAA   = 5'd25,
        OP_CPL   = 5'd26,
        OP_SCF   = 5'd27,
        OP_CCF   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADDSP = 5'd30
    } op_t;

    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    localparam logic [7:0] DAA_LIMIT    = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

    typedef struct packed {
        logic [4:0]  op;
        logic [7:0]  operand_a;
        logic [7:0]  operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
        logic [15:0] wide_a;
        logic [15:0] wide_b;
    } in_t;

    typedef struct packed {
        logic [7:0]  result;
        logic [15:0] wide_result;
        logic [3:0]  flags_out;
    } out_t;

endpackage

### hw/rtl/sm83_alu_with_flags_top.sv
`timescale 1ns / 1ps
// ============================================================================
// SM83 ALU with flags
// Three-stage pipelined SM83 arithmetic-logic unit with Z/N/H/C flag logic.
//
//   channel | role   | payload           | handshake
//   --------+--------+-------------------+------------------------
//   cmd     | input  | sm83alu_pkg::in_t | cmd_valid / cmd_ready
//   res     | output | sm83alu_pkg::out_t| res_valid / res_ready
//
// One item enters per cycle while res is not stalled; its result passes through s1_reg and s2_reg into out_reg.
// The stages are operand prep with low nibble sums, upper nibble sums with
// result selection, and zero flag plus wide top nibble into the output register.
// Reset clears all stage valid bits; payload registers are not reset.
// When res is stalled the whole pipeline holds and cmd_ready drops.
// ============================================================================
`include "sm83_alu_with_flags_top_assert.svh"

module sm83_alu_with_flags_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  sm83alu_pkg::in_t  cmd,
    output logic              res_valid,
    input  logic              res_ready,
    output sm83alu_pkg::out_t res
);

    typedef struct packed {
        logic [4:0] op;
        logic [7:0] a;
        logic [7:0] b;
        logic [2:0] bi;
        logic [3:0] f;
        logic [3:0] sum_lo;
        logic       c4;
        logic [3:0] a_hi;
        logic [3:0] y_hi;
        logic       sub;
        logic [7:0] daa_adj;
        logic       daa_cy;
        logic [7:0] w_lo;
        logic       c8w;
        logic       h3w;
        logic [7:0] wa_hi;
        logic [7:0] wy_hi;
    } s1_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] zb;
        logic       zsel;
        logic [3:0] tmpl;
        logic       use_c16;
        logic       wide;
        logic [7:0] w_lo;
        logic [3:0] w_mid;
        logic       c12;
        logic [3:0] wa_top;
        logic [3:0] wy_top;
    } s2_t;

    logic              advance;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              out_valid_reg;
    s1_t               s1_reg;
    s1_t               s1_next;
    s2_t               s2_reg;
    s2_t               s2_next;
    sm83alu_pkg::out_t out_reg;
    sm83alu_pkg::out_t out_next;

    logic              sub0;
    logic              incdec0;
    logic              cin0;
    logic              cadd0;
    logic [7:0]        y0;
    logic [7:0]        yv0;
    logic [4:0]        lo5;
    logic [15:0]       wy0;
    logic [8:0]        wlo9;
    logic [4:0]        wh5;
    logic [7:0]        adj0;
    logic              dcy0;

    logic [4:0]        hi5;
    logic [7:0]        sum8;
    logic              h1;
    logic              c1;
    logic [4:0]        wmid5;

    logic [4:0]        top5;
    logic [3:0]        flags2;

    assign advance   = !out_valid_reg || res_ready;
    assign cmd_ready = advance;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        sub0 = (cmd.op == sm83alu_pkg::OP_SUB) || (cmd.op == sm83alu_pkg::OP_SBC)
            || (cmd.op == sm83alu_pkg::OP_CP) || (cmd.op == sm83alu_pkg::OP_DEC);
        incdec0 = (cmd.op == sm83alu_pkg::OP_INC) || (cmd.op == sm83alu_pkg::OP_DEC);
        y0 = incdec0 ? 8'd1 : cmd.operand_b;
        cin0 = ((cmd.op == sm83alu_pkg::OP_ADC) || (cmd.op == sm83alu_pkg::OP_SBC))
            ? cmd.flags_in[sm83alu_pkg::FLAG_C] : 1'b0;
        yv0 = sub0 ? ~y0 : y0;
        cadd0 = sub0 ? ~cin0 : cin0;
        lo5 = {1'b0, cmd.operand_a[3:0]} + {1'b0, yv0[3:0]} + {4'd0, cadd0};

        wy0 = (cmd.op == sm83alu_pkg::OP_ADDSP)
            ? {{8{cmd.operand_b[7]}}, cmd.operand_b} : cmd.wide_b;
        wlo9 = {1'b0, cmd.wide_a[7:0]} + {1'b0, wy0[7:0]};
        wh5 = {1'b0, cmd.wide_a[3:0]} + {1'b0, wy0[3:0]};

        if (cmd.flags_in[sm83alu_pkg::FLAG_N])
        begin
            dcy0 = cmd.flags_in[sm83alu_pkg::FLAG_C];
            adj0 = 8'd0;
            if (cmd.flags_in[sm83alu_pkg::FLAG_C])
            begin
                adj0 = adj0 - sm83alu_pkg::DAA_HI_ADJ;
            end
            if (cmd.flags_in[sm83alu_pkg::FLAG_H])
            begin
                adj0 = adj0 - sm83alu_pkg::DAA_LO_ADJ;
            end
        end
        else
        begin
            dcy0 = cmd.flags_in[sm83alu_pkg::FLAG_C]
                || (cmd.operand_a > sm83alu_pkg::DAA_LIMIT);
            adj0 = dcy0 ? sm83alu_pkg::DAA_HI_ADJ : 8'd0;
            if (cmd.flags_in[sm83alu_pkg::FLAG_H]
                || (cmd.operand_a[3:0] > sm83alu_pkg::DAA_LO_LIMIT))
            begin
                adj0 = adj0 + sm83alu_pkg::DAA_LO_ADJ;
            end
        end

        s1_next.op      = cmd.op;
        s1_next.a       = cmd.operand_a;
        s1_next.b       = cmd.operand_b;
        s1_next.bi      = cmd.bit_index;
        s1_next.f       = cmd.flags_in;
        s1_next.sum_lo  = lo5[3:0];
        s1_next.c4      = lo5[4];
        s1_next.a_hi    = cmd.operand_a[7:4];
        s1_next.y_hi    = yv0[7:4];
        s1_next.sub     = sub0;
        s1_next.daa_adj = adj0;
        s1_next.daa_cy  = dcy0;
        s1_next.w_lo    = wlo9[7:0];
        s1_next.c8w     = wlo9[8];
        s1_next.h3w     = wh5[4];
        s1_next.wa_hi   = cmd.wide_a[15:8];
        s1_next.wy_hi   = wy0[15:8];
    end

    always_comb
    begin
        hi5 = {1'b0, s1_reg.a_hi} + {1'b0, s1_reg.y_hi} + {4'd0, s1_reg.c4};
        sum8 = {hi5[3:0], s1_reg.sum_lo};
        h1 = s1_reg.sub ? ~s1_reg.c4 : s1_reg.c4;
        c1 = s1_reg.sub ? ~hi5[4] : hi5[4];
        wmid5 = {1'b0, s1_reg.wa_hi[3:0]} + {1'b0, s1_reg.wy_hi[3:0]}
            + {4'd0, s1_reg.c8w};

        s2_next.r       = s1_reg.a;
        s2_next.zsel    = 1'b0;
        s2_next.tmpl    = s1_reg.f;
        s2_next.use_c16 = 1'b0;
        s2_next.wide    = 1'b0;

        unique case (s1_reg.op)
            sm83alu_pkg::OP_ADD, sm83alu_pkg::OP_ADC,
            sm83alu_pkg::OP_SUB, sm83alu_pkg::OP_SBC:
            begin
                s2_next.r    = sum8;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {1'b0, s1_reg.sub, h1, c1};
            end
            sm83alu_pkg::OP_CP:
            begin
                s2_next.r    = s1_reg.a;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {1'b0, 1'b1, h1, c1};
            end
            sm83alu_pkg::OP_INC, sm83alu_pkg::OP_DEC:
            begin
                s2_next.r    = sum8;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {1'b0, s1_reg.sub, h1, s1_reg.f[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_AND:
            begin
                s2_next.r    = s1_reg.a & s1_reg.b;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = 4'b0010;
            end
            sm83alu_pkg::OP_XOR:
            begin
                s2_next.r    = s1_reg.a ^ s1_reg.b;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = 4'b0000;
            end
            sm83alu_pkg::OP_OR:
            begin
                s2_next.r    = s1_reg.a | s1_reg.b;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = 4'b0000;
            end
            sm83alu_pkg::OP_RLCA, sm83alu_pkg::OP_RLC:
            begin
                s2_next.r    = {s1_reg.a[6:0], s1_reg.a[7]};
                s2_next.zsel = (s1_reg.op == sm83alu_pkg::OP_RLC);
                s2_next.tmpl = {3'b000, s1_reg.a[7]};
            end
            sm83alu_pkg::OP_RLA, sm83alu_pkg::OP_RL:
            begin
                s2_next.r    = {s1_reg.a[6:0], s1_reg.f[sm83alu_pkg::FLAG_C]};
                s2_next.zsel = (s1_reg.op == sm83alu_pkg::OP_RL);
                s2_next.tmpl = {3'b000, s1_reg.a[7]};
            end
            sm83alu_pkg::OP_RRCA, sm83alu_pkg::OP_RRC:
            begin
                s2_next.r    = {s1_reg.a[0], s1_reg.a[7:1]};
                s2_next.zsel = (s1_reg.op == sm83alu_pkg::OP_RRC);
                s2_next.tmpl = {3'b000, s1_reg.a[0]};
            end
            sm83alu_pkg::OP_RRA, sm83alu_pkg::OP_RR:
            begin
                s2_next.r    = {s1_reg.f[sm83alu_pkg::FLAG_C], s1_reg.a[7:1]};
                s2_next.zsel = (s1_reg.op == sm83alu_pkg::OP_RR);
                s2_next.tmpl = {3'b000, s1_reg.a[0]};
            end
            sm83alu_pkg::OP_SLA:
            begin
                s2_next.r    = {s1_reg.a[6:0], 1'b0};
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {3'b000, s1_reg.a[7]};
            end
            sm83alu_pkg::OP_SRA:
            begin
                s2_next.r    = {s1_reg.a[7], s1_reg.a[7:1]};
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {3'b000, s1_reg.a[0]};
            end
            sm83alu_pkg::OP_SWAP:
            begin
                s2_next.r    = {s1_reg.a[3:0], s1_reg.a[7:4]};
                s2_next.zsel = 1'b1;
                s2_next.tmpl = 4'b0000;
            end
            sm83alu_pkg::OP_SRL:
            begin
                s2_next.r    = {1'b0, s1_reg.a[7:1]};
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {3'b000, s1_reg.a[0]};
            end
            sm83alu_pkg::OP_BIT:
            begin
                s2_next.r    = s1_reg.a;
                s2_next.tmpl = {~s1_reg.a[s1_reg.bi], 1'b0, 1'b1,
                                s1_reg.f[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_RES:
            begin
                s2_next.r = s1_reg.a & ~(8'd1 << s1_reg.bi);
            end
            sm83alu_pkg::OP_SET:
            begin
                s2_next.r = s1_reg.a | (8'd1 << s1_reg.bi);
            end
            sm83alu_pkg::OP_DAA:
            begin
                s2_next.r    = s1_reg.a + s1_reg.daa_adj;
                s2_next.zsel = 1'b1;
                s2_next.tmpl = {1'b0, s1_reg.f[sm83alu_pkg::FLAG_N], 1'b0, s1_reg.daa_cy};
            end
            sm83alu_pkg::OP_CPL:
            begin
                s2_next.r    = ~s1_reg.a;
                s2_next.tmpl = s1_reg.f | 4'b0110;
            end
            sm83alu_pkg::OP_SCF:
            begin
                s2_next.tmpl = {s1_reg.f[sm83alu_pkg::FLAG_Z], 3'b001};
            end
            sm83alu_pkg::OP_CCF:
            begin
                s2_next.tmpl = {s1_reg.f[sm83alu_pkg::FLAG_Z], 2'b00,
                                ~s1_reg.f[sm83alu_pkg::FLAG_C]};
            end
            sm83alu_pkg::OP_ADD16:
            begin
                s2_next.r       = 8'd0;
                s2_next.wide    = 1'b1;
                s2_next.use_c16 = 1'b1;
                s2_next.tmpl    = {s1_reg.f[sm83alu_pkg::FLAG_Z], 1'b0, wmid5[4], 1'b0};
            end
            sm83alu_pkg::OP_ADDSP:
            begin
                s2_next.r    = 8'd0;
                s2_next.wide = 1'b1;
                s2_next.tmpl = {2'b00, s1_reg.h3w, s1_reg.c8w};
            end
            default:
            begin
                s2_next.r    = s1_reg.a;
                s2_next.tmpl = s1_reg.f;
            end
        endcase

        s2_next.zb     = (s1_reg.op == sm83alu_pkg::OP_CP) ? sum8 : s2_next.r;
        s2_next.w_lo   = s1_reg.w_lo;
        s2_next.w_mid  = wmid5[3:0];
        s2_next.c12    = wmid5[4];
        s2_next.wa_top = s1_reg.wa_hi[7:4];
        s2_next.wy_top = s1_reg.wy_hi[7:4];
    end

    always_comb
    begin
        top5 = {1'b0, s2_reg.wa_top} + {1'b0, s2_reg.wy_top} + {4'd0, s2_reg.c12};
        flags2 = s2_reg.tmpl;
        if (s2_reg.zsel)
        begin
            flags2[sm83alu_pkg::FLAG_Z] = (s2_reg.zb == 8'd0);
        end
        if (s2_reg.use_c16)
        begin
            flags2[sm83alu_pkg::FLAG_C] = top5[4];
        end
        out_next.result      = s2_reg.r;
        out_next.wide_result = s2_reg.wide
            ? {top5[3:0], s2_reg.w_mid, s2_reg.w_lo} : 16'd0;
        out_next.flags_out   = flags2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= cmd_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg  <= s1_next;
            s2_reg  <= s2_next;
            out_reg <= out_next;
        end
    end

    `SM83_ASSERT_NEXT(a_s1_moves_to_s2, advance && s1_valid_reg, s2_valid_reg)
    `SM83_ASSERT_NEXT(a_stall_holds_valids, !advance,
        $stable(s1_valid_reg) && $stable(s2_valid_reg) && out_valid_reg)
    `SM83_ASSERT_NEXT(a_wide_op_byte_zero, advance && s2_valid_reg && s2_reg.wide,
        out_reg.result == 8'd0)
    `SM83_ASSERT_NEXT(a_byte_op_wide_zero, advance && s2_valid_reg && !s2_reg.wide,
        out_reg.wide_result == 16'd0)
    `SM83_ASSERT(a_ready_only_when_free, cmd_ready || out_valid_reg)

endmodule
